// File: hdl/morse_receive_decoder_assert.svh
// Assertion macros used by the decoder's top-level RTL file.
// Each macro expands to one labeled concurrent assertion that is
// disabled while the active-low reset is asserted.
`ifndef MORSE_RECEIVE_DECODER_ASSERT_SVH
`define MORSE_RECEIVE_DECODER_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds at that edge.
`define MRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrd assertion failed");

// Next-cycle implication: whenever ante holds, cons holds at the next edge.
`define MRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrd assertion failed");

`endif

// File: hdl/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types, codes and constants of the Morse receive decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrd_pkg;

  // Default tree root; the position of the empty letter.
  localparam int unsigned TreeRootDef = 64;

  // Field widths fixed by the interface.
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TreeIdxW = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam int unsigned UnitW     = 11;
  localparam int unsigned DashW     = 4;
  localparam int unsigned LetterGapW = 4;
  localparam int unsigned WordGapW  = 5;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_UNIT_TIME        = 2'd0,
    CFG_DASH_UNITS       = 2'd1,
    CFG_LETTER_GAP_UNITS = 2'd2,
    CFG_WORD_GAP_UNITS   = 2'd3
  } mrd_cfg_idx_e;

  // What the line did last, as far as the gap timing is concerned.
  typedef enum logic [1:0] {
    ELEM_NONE = 2'd0,
    ELEM_MARK = 2'd1,
    ELEM_LGAP = 2'd2,
    ELEM_WGAP = 2'd3
  } mrd_elem_e;

  typedef enum logic {
    EVT_LETTER = 1'b0,
    EVT_WORD   = 1'b1
  } mrd_event_e;

  typedef struct packed {
    logic [UnitW-1:0]      unit_time;
    logic [DashW-1:0]      dash_units;
    logic [LetterGapW-1:0] letter_gap_units;
    logic [WordGapW-1:0]   word_gap_units;
  } mrd_cfg_t;

  // Timing control state of the decoder.
  typedef struct packed {
    logic             line_state;
    logic [TimeW-1:0] mark_start;
    mrd_elem_e        last_elem;
  } mrd_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/mrd_if.sv
// ----------------------------------------------------------------------------
// mrd_if
// Valid/ready channel interfaces of the Morse receive decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Line samples into the decoder.
interface mrd_sample_if;
  logic        valid;
  logic        ready;
  logic        line_level;
  logic [31:0] now_time;

  modport source (output valid, output line_level, output now_time, input ready);
  modport sink   (input valid, input line_level, input now_time, output ready);
endinterface

// Letter and word events out of the decoder.
interface mrd_event_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [6:0] tree_index;

  modport source (output valid, output event_kind, output tree_index, input ready);
  modport sink   (input valid, input event_kind, input tree_index, output ready);
endinterface

// Configuration register writes.
interface mrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/morse_receive_decoder.sv
// ----------------------------------------------------------------------------
// morse_receive_decoder
// Morse receiver: times a sampled keyed line and walks the dichotomic tree.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i carries one item per line sample: the line level (1 = mark) and
//   a free-running millisecond timestamp that wraps at 2^32. event_o carries
//   zero or one item per sample: a completed letter with its tree index, or a
//   word space that reports the tree root. cfg_i writes the four timing
//   registers (unit time, dash, letter gap and word gap lengths in units);
//   it is always ready and must only be used while the decoder is idle.
//   Each sample is taken into an input register and decoded by one pass of
//   compare and add logic in the following cycle; any event it causes is
//   loaded into the output register, from which it is offered on event_o.
//   One sample is accepted per cycle while no held sample waits to emit.
//   When the event receiver stalls, samples that cause no event keep flowing;
//   a sample that would emit waits in the input register until the output
//   register frees, and sample_i.ready drops behind it.
//   Reset puts the line at space, the mark start time at zero, the tree at
//   its root and the timing registers at 60 ms, 3, 3 and 7 units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "morse_receive_decoder_assert.svh"

module morse_receive_decoder import mrd_pkg::*; #(
  parameter int unsigned TREE_ROOT = TreeRootDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mrd_sample_if.sink   sample_i,
  mrd_event_if.source  event_o,
  mrd_cfg_if.sink      cfg_i
);

  localparam int unsigned PosW  = $clog2(2 * TREE_ROOT);
  localparam int unsigned StepW = $clog2(TREE_ROOT);
  localparam logic [PosW-1:0]  RootPos  = PosW'(TREE_ROOT);
  localparam logic [StepW-1:0] RootStep = StepW'(TREE_ROOT / 2);

  // Timing registers.
  mrd_cfg_t cfg_q;

  // Input register.
  logic             s1_valid_q;
  logic             s1_level_q;
  logic [TimeW-1:0] s1_now_q;

  // Decoder state.
  mrd_ctrl_t        ctrl_q, ctrl_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [StepW-1:0] step_q, step_d;

  // Output register.
  logic                out_valid_q;
  mrd_event_e          out_kind_q;
  logic [TreeIdxW-1:0] out_index_q;

  logic                step_emit;
  mrd_event_e          step_kind;
  logic [TreeIdxW-1:0] step_index;
  logic                advance;
  logic                out_load;

  // The configuration port never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_time        <= UnitW'(60);
      cfg_q.dash_units       <= DashW'(3);
      cfg_q.letter_gap_units <= LetterGapW'(3);
      cfg_q.word_gap_units   <= WordGapW'(7);
    end else if (cfg_i.valid) begin
      case (mrd_cfg_idx_e'(cfg_i.index))
        CFG_UNIT_TIME:        cfg_q.unit_time        <= cfg_i.data;
        CFG_DASH_UNITS:       cfg_q.dash_units       <= cfg_i.data[DashW-1:0];
        CFG_LETTER_GAP_UNITS: cfg_q.letter_gap_units <= cfg_i.data[LetterGapW-1:0];
        CFG_WORD_GAP_UNITS:   cfg_q.word_gap_units   <= cfg_i.data[WordGapW-1:0];
        default: ;
      endcase
    end
  end

  mrd_step #(
    .TREE_ROOT (TREE_ROOT)
  ) u_step (
    .cfg_i        (cfg_q),
    .ctrl_i       (ctrl_q),
    .pos_i        (pos_q),
    .step_i       (step_q),
    .line_level_i (s1_level_q),
    .now_time_i   (s1_now_q),
    .ctrl_o       (ctrl_d),
    .pos_o        (pos_d),
    .step_o       (step_d),
    .emit_o       (step_emit),
    .kind_o       (step_kind),
    .index_o      (step_index)
  );

  // The held sample is decoded once there is room for whatever it emits.
  assign advance  = s1_valid_q && (!step_emit || !out_valid_q || event_o.ready);
  assign out_load = advance && step_emit;

  assign sample_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      s1_level_q <= sample_i.line_level;
      s1_now_q   <= sample_i.now_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.line_state <= 1'b0;
      ctrl_q.mark_start <= '0;
      ctrl_q.last_elem  <= ELEM_NONE;
      pos_q             <= RootPos;
      step_q            <= RootStep;
    end else if (advance) begin
      ctrl_q <= ctrl_d;
      pos_q  <= pos_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (event_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q  <= step_kind;
      out_index_q <= step_index;
    end
  end

  assign event_o.valid      = out_valid_q;
  assign event_o.event_kind = out_kind_q;
  assign event_o.tree_index = out_index_q;

  // The walk never leaves the tree: the position stays above zero.
  `MRD_ASSERT_NOW(a_pos_nonzero, clk_i, rst_ni, 1'b1, pos_q != '0)
  // A word space always reports the root.
  `MRD_ASSERT_NOW(a_word_is_root, clk_i, rst_ni,
                  out_valid_q && out_kind_q == EVT_WORD, out_index_q == TreeIdxW'(RootPos))
  // Loading a word space leaves the gap tracker in the word-gap state.
  `MRD_ASSERT_NEXT(a_word_state, clk_i, rst_ni,
                   out_load && step_kind == EVT_WORD, ctrl_q.last_elem == ELEM_WGAP)

endmodule

`default_nettype wire

// File: hdl/mrd_step.sv
// ----------------------------------------------------------------------------
// mrd_step
// Next-state logic for one line sample: mark/space timing and tree walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrd_step import mrd_pkg::*; #(
  parameter int unsigned TREE_ROOT = TreeRootDef,
  localparam int unsigned PosW  = $clog2(2 * TREE_ROOT),
  localparam int unsigned StepW = $clog2(TREE_ROOT)
) (
  input  wire mrd_cfg_t          cfg_i,
  input  wire mrd_ctrl_t         ctrl_i,
  input  wire logic [PosW-1:0]   pos_i,
  input  wire logic [StepW-1:0]  step_i,
  input  wire logic              line_level_i,
  input  wire logic [TimeW-1:0]  now_time_i,
  output mrd_ctrl_t              ctrl_o,
  output logic [PosW-1:0]        pos_o,
  output logic [StepW-1:0]       step_o,
  output logic                   emit_o,
  output mrd_event_e             kind_o,
  output logic [TreeIdxW-1:0]    index_o
);

  localparam logic [PosW-1:0]  RootPos  = PosW'(TREE_ROOT);
  localparam logic [StepW-1:0] RootStep = StepW'(TREE_ROOT / 2);

  logic [TimeW-1:0] elapsed;
  logic [4:0]       letter_sum;
  logic [5:0]       word_sum;
  logic [15:0]      letter_thr;
  logic [16:0]      word_thr;
  logic [14:0]      dash_thr;
  logic             letter_met;
  logic             word_met;
  logic             is_dash;
  logic             is_dot;

  assign elapsed    = now_time_i - ctrl_i.mark_start;
  assign letter_sum = 5'd1 + 5'(cfg_i.letter_gap_units);
  assign word_sum   = 6'd1 + 6'(cfg_i.letter_gap_units) + 6'(cfg_i.word_gap_units);
  assign letter_thr = 16'(cfg_i.unit_time) * 16'(letter_sum);
  assign word_thr   = 17'(cfg_i.unit_time) * 17'(word_sum);
  assign dash_thr   = 15'(cfg_i.unit_time) * 15'(cfg_i.dash_units);

  assign letter_met = elapsed >= TimeW'(letter_thr);
  assign word_met   = elapsed >= TimeW'(word_thr);
  assign is_dash    = elapsed >= TimeW'(dash_thr);
  assign is_dot     = elapsed >= TimeW'(cfg_i.unit_time >> 1);

  // Next state. Gaps are only timed while the line rests at space; a mark
  // that ends too soon is ignored and keeps being timed.
  always_comb begin
    ctrl_o = ctrl_i;
    pos_o  = pos_i;
    step_o = step_i;
    emit_o = 1'b0;
    kind_o = EVT_LETTER;
    if (!ctrl_i.line_state) begin
      if (ctrl_i.last_elem == ELEM_LGAP && word_met) begin
        ctrl_o.last_elem = ELEM_WGAP;
        pos_o  = RootPos;
        step_o = RootStep;
        emit_o = 1'b1;
        kind_o = EVT_WORD;
      end else if (ctrl_i.last_elem == ELEM_MARK && letter_met) begin
        ctrl_o.last_elem = ELEM_LGAP;
        pos_o  = RootPos;
        step_o = RootStep;
        emit_o = 1'b1;
        kind_o = EVT_LETTER;
      end
      if (line_level_i) begin
        ctrl_o.mark_start = now_time_i;
        ctrl_o.line_state = 1'b1;
      end
    end else if (!line_level_i && (is_dash || is_dot)) begin
      if (is_dash) begin
        pos_o = pos_i + PosW'(step_i);
      end else begin
        pos_o = pos_i - PosW'(step_i);
      end
      step_o            = step_i >> 1;
      ctrl_o.last_elem  = ELEM_MARK;
      ctrl_o.mark_start = now_time_i;
      ctrl_o.line_state = 1'b0;
    end
  end

  // Event payload: a letter reports the position it ended on, a word space
  // reports the root.
  always_comb begin
    case (kind_o)
      EVT_WORD: index_o = TreeIdxW'(RootPos);
      EVT_LETTER: index_o = TreeIdxW'(pos_i);
      default: index_o = TreeIdxW'(pos_i);
    endcase
  end

endmodule

`default_nettype wire

// File: sim/morse_receive_decoder_tb.sv
// ----------------------------------------------------------------------------
// morse_receive_decoder_tb
// Self-checking testbench of the Morse receive decoder.
// ----------------------------------------------------------------------------
// Line samples go in through the sample channel and letter and word events
// come back on the event channel. A predictor inside a small scoreboard class
// follows every accepted sample and keeps the events it expects in order.
// Each event that leaves the block is checked against the oldest of them.
// The run starts with a short keyed sequence at the reset timing, then works
// through several timing settings with mostly well-formed keying.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module morse_receive_decoder_tb;
  import mrd_pkg::*;

  localparam int unsigned ROOT        = TreeRootDef;
  localparam int          IDLE_PCT    = 27;
  localparam int          HOLD_CYCLES = 400;
  localparam int          SETTLE      = 8;
  localparam int          CYCLE_LIMIT = 300000;

  // Timing registers as they stand after reset.
  localparam logic [UnitW-1:0]      UNIT_RST  = 11'd60;
  localparam logic [DashW-1:0]      DASH_RST  = 4'd3;
  localparam logic [LetterGapW-1:0] LGAP_RST  = 4'd3;
  localparam logic [WordGapW-1:0]   WGAP_RST  = 5'd7;

  typedef struct packed {
    mrd_event_e                kind;
    logic [TreeIdxW-1:0]       index;
  } morse_event_t;

  // --------------------------------------------------------------------------
  // Letter predictor: mirrors the line timing and the tree walk, and holds
  // the events that the block still owes.
  // --------------------------------------------------------------------------
  class letter_predictor;
    mrd_cfg_t            timing;
    logic                line_mark;
    logic [TimeW-1:0]    mark_start;
    mrd_elem_e           last_elem;
    logic [TreeIdxW-1:0] tree_pos;
    logic [5:0]          tree_step;
    morse_event_t        due_events[$];
    int                  mismatches;

    function new();
      timing.unit_time        = UNIT_RST;
      timing.dash_units       = DASH_RST;
      timing.letter_gap_units = LGAP_RST;
      timing.word_gap_units   = WGAP_RST;
      line_mark  = 1'b0;
      mark_start = '0;
      last_elem  = ELEM_NONE;
      back_to_root();
      mismatches = 0;
    endfunction

    function void back_to_root();
      tree_pos  = TreeIdxW'(ROOT);
      tree_step = 6'(ROOT / 2);
    endfunction

    function void write_reg(input mrd_cfg_idx_e idx, input logic [CfgDataW-1:0] data);
      case (idx)
        CFG_UNIT_TIME:        timing.unit_time        = data[UnitW-1:0];
        CFG_DASH_UNITS:       timing.dash_units       = data[DashW-1:0];
        CFG_LETTER_GAP_UNITS: timing.letter_gap_units = data[LetterGapW-1:0];
        CFG_WORD_GAP_UNITS:   timing.word_gap_units   = data[WordGapW-1:0];
        default: ;
      endcase
    endfunction

    // Notes one accepted sample and queues the event that it causes, if any.
    function void take_sample(input logic level, input logic [TimeW-1:0] now);
      logic [31:0]  elapsed;
      logic [31:0]  unit;
      logic [31:0]  letter_thr;
      logic [31:0]  word_thr;
      morse_event_t ev;
      elapsed = now - mark_start;
      unit    = 32'(timing.unit_time);
      if (!line_mark) begin
        letter_thr = unit * (32'd1 + 32'(timing.letter_gap_units));
        word_thr   = unit * (32'd1 + 32'(timing.letter_gap_units)
                                   + 32'(timing.word_gap_units));
        if (last_elem == ELEM_LGAP && elapsed >= word_thr) begin
          last_elem = ELEM_WGAP;
          back_to_root();
          ev.kind  = EVT_WORD;
          ev.index = TreeIdxW'(ROOT);
          due_events.push_back(ev);
        end else if (last_elem == ELEM_MARK && elapsed >= letter_thr) begin
          last_elem = ELEM_LGAP;
          ev.kind  = EVT_LETTER;
          ev.index = tree_pos;
          due_events.push_back(ev);
          back_to_root();
        end
        if (level) begin
          mark_start = now;
          line_mark  = 1'b1;
        end
      end else if (!level) begin
        // A falling edge shorter than half a unit leaves the mark running.
        if (elapsed >= unit * 32'(timing.dash_units)) begin
          tree_pos = tree_pos + 7'(tree_step);
        end else if (elapsed >= (unit >> 1)) begin
          tree_pos = tree_pos - 7'(tree_step);
        end else begin
          return;
        end
        tree_step  = tree_step >> 1;
        last_elem  = ELEM_MARK;
        mark_start = now;
        line_mark  = 1'b0;
      end
    endfunction

    function void check_event(input logic kind, input logic [TreeIdxW-1:0] index);
      morse_event_t want;
      if (due_events.size() == 0) begin
        $display("%0t: unexpected event, kind %0d index %0d", $time, kind, index);
        mismatches++;
        return;
      end
      want = due_events.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: event kind expected %0d actual %0d", $time, want.kind, kind);
        mismatches++;
      end
      if (index !== want.index) begin
        $display("%0t: tree index expected %0d actual %0d", $time, want.index, index);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return due_events.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block.
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  mrd_sample_if smp ();
  mrd_event_if  evt ();
  mrd_cfg_if    cfg ();

  morse_receive_decoder DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp),
    .event_o  (evt),
    .cfg_i    (cfg)
  );

  letter_predictor sb;

  // Stimulus state. The line clock is the millisecond time of the keying and
  // wraps freely; the timing copy follows every register write.
  logic [TimeW-1:0] line_clock;
  mrd_cfg_t         setting;
  int               sent_items = 0;
  bit               tx_calm    = 1'b0;
  bit               rx_calm    = 1'b0;
  bit               hold_req   = 1'b0;
  bit               hold_done  = 1'b0;
  int               hold_left  = 0;
  int               cycles     = 0;

  // --------------------------------------------------------------------------
  // Monitor. All three channels are sampled at the rising edge, before the
  // nonblocking updates of that edge land. An event always leaves at a later
  // edge than the one that took its sample, so the order of the calls in one
  // edge is free.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) begin
        sb.write_reg(mrd_cfg_idx_e'(cfg.index), cfg.data);
      end
      if (smp.valid && smp.ready) begin
        sb.take_sample(smp.line_level, smp.now_time);
      end
      if (evt.valid && evt.ready) begin
        sb.check_event(evt.event_kind, evt.tree_index);
      end
    end
  end

  // Event receiver. It stalls in about a quarter of the cycles, not at all
  // while the calm flag is up, and once holds off for a long stretch so that
  // the output register fills and the block pushes back on its samples.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      evt.ready <= 1'b0;
    end else if (rx_calm) begin
      evt.ready <= 1'b1;
    end else begin
      evt.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog. A lost event keeps the final drain waiting and ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers.
  // --------------------------------------------------------------------------

  // Offers one sample item and returns at the edge that accepts it. Valid is
  // left high, so back-to-back items go out without a bubble.
  task automatic drive_sample(input logic level, input logic [TimeW-1:0] stamp);
    if (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    smp.valid      <= 1'b1;
    smp.line_level <= level;
    smp.now_time   <= stamp;
    do @(posedge clk_i); while (!smp.ready);
    sent_items++;
  endtask

  // Stops the samples and waits until every expected event is out, then lets
  // the block settle so that samples without an event have drained as well.
  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Writes all four timing registers while the block is idle. The narrow
  // registers get random junk above their width, which the block must drop.
  task automatic program_timing(input logic [UnitW-1:0] unit,
                                input logic [DashW-1:0] dash,
                                input logic [LetterGapW-1:0] lgap,
                                input logic [WordGapW-1:0] wgap);
    mrd_cfg_idx_e        order[4];
    logic [CfgDataW-1:0] data;
    order = '{CFG_UNIT_TIME, CFG_DASH_UNITS, CFG_LETTER_GAP_UNITS, CFG_WORD_GAP_UNITS};
    foreach (order[i]) begin
      case (order[i])
        CFG_UNIT_TIME:        data = unit;
        CFG_DASH_UNITS:       data = {7'($urandom), dash};
        CFG_LETTER_GAP_UNITS: data = {7'($urandom), lgap};
        default:              data = {6'($urandom), wgap};
      endcase
      cfg.valid <= 1'b1;
      cfg.index <= order[i];
      cfg.data  <= data;
      do @(posedge clk_i); while (!cfg.ready);
    end
    cfg.valid <= 1'b0;
    setting.unit_time        = unit;
    setting.dash_units       = dash;
    setting.letter_gap_units = lgap;
    setting.word_gap_units   = wgap;
  endtask

  // --------------------------------------------------------------------------
  // Durations, drawn around the thresholds of the current timing.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] around(input logic [31:0] x);
    logic [31:0] d;
    d = $urandom_range(0, 2);
    if (x == 0 && d == 0) return 32'd0;
    return x + d - 32'd1;
  endfunction

  function automatic logic [31:0] letter_thr();
    return 32'(setting.unit_time) * (32'd1 + 32'(setting.letter_gap_units));
  endfunction

  function automatic logic [31:0] word_thr();
    return 32'(setting.unit_time) * (32'd1 + 32'(setting.letter_gap_units)
                                           + 32'(setting.word_gap_units));
  endfunction

  function automatic logic [31:0] mark_len();
    logic [31:0] unit;
    logic [31:0] dot;
    logic [31:0] dash;
    unit = 32'(setting.unit_time);
    dot  = unit >> 1;
    dash = unit * 32'(setting.dash_units);
    case ($urandom_range(9))
      0:       return (dot == 0) ? 32'd0 : $urandom_range(0, dot - 1);
      1:       return around(dot);
      2:       return around(dash);
      3, 4, 5: return $urandom_range(dot, dash);
      9:       return $urandom;
      default: return $urandom_range(dash, dash + 2 * unit + 1);
    endcase
  endfunction

  function automatic logic [31:0] gap_len(input bit in_letter);
    logic [31:0] lt;
    logic [31:0] wt;
    lt = letter_thr();
    wt = word_thr();
    if (in_letter) begin
      // Mostly a gap between elements; now and then one that ends the letter.
      if ($urandom_range(7) == 0) return around(lt);
      return (lt == 0) ? 32'd0 : $urandom_range(0, lt - 1);
    end
    case ($urandom_range(5))
      0:       return around(lt);
      1, 4:    return $urandom_range(lt, wt);
      2:       return around(wt);
      3:       return $urandom_range(wt, 2 * wt + 1);
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Keying.
  // --------------------------------------------------------------------------

  // One mark: the rising edge, a few samples inside it, the falling edge.
  task automatic key_mark();
    logic [31:0] len;
    logic [31:0] off;
    len = mark_len();
    off = 0;
    drive_sample(1'b1, line_clock);
    repeat ($urandom_range(0, 2)) begin
      off = $urandom_range(off, len);
      drive_sample(1'b1, line_clock + off);
    end
    line_clock = line_clock + len;
    drive_sample(1'b0, line_clock);
  endtask

  // One silence. Samples inside it let the gap events fire before the next
  // rising edge; without them the event comes with that edge.
  task automatic key_space(input bit in_letter);
    logic [31:0] len;
    logic [31:0] off;
    len = gap_len(in_letter);
    off = 0;
    repeat ($urandom_range(in_letter ? 0 : 1, 3)) begin
      off = $urandom_range(off, len);
      drive_sample(1'b0, line_clock + off);
    end
    line_clock = line_clock + len;
  endtask

  // One letter; about one in ten is long enough to run the tree step to zero.
  task automatic key_letter();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      key_mark();
      key_space(i < n - 1);
    end
  endtask

  // Random traffic: mostly keyed letters with random content, the rest noise
  // (random levels, random or jumping timestamps) and broken keying.
  task automatic run_traffic(input int count);
    int          goal;
    logic [31:0] unit;
    goal = sent_items + count;
    while (sent_items < goal) begin
      unit = 32'(setting.unit_time);
      case ($urandom_range(19))
        0, 1: begin
          if ($urandom_range(1)) line_clock = $urandom;
          else line_clock = line_clock + $urandom_range(0, 3 * unit + 1);
          drive_sample(1'(($urandom)), line_clock);
        end
        2: begin
          // Mostly a glitch: a rising edge and a fall no later than half a unit.
          drive_sample(1'b1, line_clock);
          line_clock = line_clock + $urandom_range(0, unit >> 1);
          drive_sample(1'b0, line_clock);
        end
        3: begin
          // Repeated sample, then time running backwards.
          drive_sample(1'(($urandom)), line_clock);
          drive_sample(1'(($urandom)), line_clock);
          line_clock = line_clock - $urandom_range(0, 4 * unit + 1);
        end
        default: key_letter();
      endcase
    end
  endtask

  // Directed keying at the reset timing (60 ms unit). Time starts just below
  // the wrap point. It covers a short mark that is ignored, a dot and a dash
  // on the exact thresholds, a silence one short of the letter gap and then
  // on it, a word gap together with a rising edge, and a letter of eight
  // dashes that runs the tree step down to zero and stops at the top leaf.
  task automatic directed_walk();
    logic [31:0] t;
    t = 32'hFFFF_FF00;
    drive_sample(1'b1, t);
    drive_sample(1'b0, t + 32'd10);
    drive_sample(1'b0, t + 32'd30);
    drive_sample(1'b1, t + 32'd100);
    drive_sample(1'b0, t + 32'd280);
    drive_sample(1'b0, t + 32'd519);
    drive_sample(1'b0, t + 32'd520);
    t = t + 32'd280 + 32'd660;
    drive_sample(1'b1, t);
    for (int i = 0; i < 8; i++) begin
      if (i > 0) begin
        t = t + 32'd60;
        drive_sample(1'b1, t);
      end
      t = t + 32'd180;
      drive_sample(1'b0, t);
    end
    drive_sample(1'b0, t + 32'd240);
    drive_sample(1'b0, t + 32'd900);
    line_clock = t + 32'd1000;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    smp.valid      = 1'b0;
    smp.line_level = 1'b0;
    smp.now_time   = '0;
    cfg.valid      = 1'b0;
    cfg.index      = CFG_UNIT_TIME;
    cfg.data       = '0;
    evt.ready      = 1'b0;
    setting.unit_time        = UNIT_RST;
    setting.dash_units       = DASH_RST;
    setting.letter_gap_units = LGAP_RST;
    setting.word_gap_units   = WGAP_RST;
    sb = new();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_walk();
    run_traffic(275);
    drain();

    // Timing settings: the low extremes, the high extremes, all zero (every
    // mark a dash, every silence a gap), the top of the nominal range, a few
    // random ones, and back to the reset values.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       program_timing(11'd1, 4'd1, 4'd1, 5'd1);
        1:       program_timing(11'h7FF, 4'hF, 4'hF, 5'h1F);
        2:       program_timing(11'd0, 4'd0, 4'd0, 5'd0);
        3:       program_timing(11'd1200, 4'hF, 4'hF, 5'h1F);
        7:       program_timing(UNIT_RST, DASH_RST, LGAP_RST, WGAP_RST);
        default: program_timing(11'($urandom_range(1, 300)), 4'($urandom_range(1, 15)),
                                4'($urandom_range(1, 15)), 5'($urandom_range(1, 31)));
      endcase
      // The long receiver hold-off comes in the low-extreme setting, where
      // events are frequent; the next setting runs with no idling at all.
      if (p == 0) hold_req <= 1'b1;
      if (p == 1) begin
        tx_calm = 1'b1;
        rx_calm <= 1'b1;
      end
      run_traffic(155);
      drain();
      tx_calm = 1'b0;
      rx_calm <= 1'b0;
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
